// ===== hw/rtl/gjk_pkg.sv =====
// ----------------------------------------------------------------------------
// GJK overlap test package
// Shared types, operation and outcome codes, and saturating Q-format helpers.
// ----------------------------------------------------------------------------
package gjk_pkg;

	typedef enum logic [2:0] {
		OP_CLEAR    = 3'd0,
		OP_VERTEX   = 3'd1,
		OP_POSITION = 3'd2,
		OP_ORIGIN   = 3'd3,
		OP_SCALE    = 3'd4,
		OP_COG      = 3'd5,
		OP_ROTATION = 3'd6,
		OP_TEST     = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		OUT_EMPTY       = 3'd0,
		OUT_FIRST_SHORT = 3'd1,
		OUT_LATER_SHORT = 3'd2,
		OUT_ENCLOSED    = 3'd3,
		OUT_LIMIT       = 3'd4
	} outcome_t;

	localparam logic [0:0] CFG_MAX_ITER = 1'b0;
	localparam logic [0:0] CFG_EPSILON  = 1'b1;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
	} vec_t;

	typedef struct packed {
		op_t  op;
		logic polygon;
		vec_t v;
		logic is_test;
	} item_t;

	typedef struct packed {
		logic [6:0]  max_iter;
		logic [15:0] eps;
	} cfg_t;

	typedef struct packed {
		logic     valid;
		logic     collides;
		outcome_t outcome;
		logic [6:0] used;
	} result_t;

	function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
		logic signed [31:0] r;
		if (v > 65'sh0_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -65'sh0_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [31:0] sadd(input logic signed [31:0] a,
		input logic signed [31:0] b);
		return sat32(65'(a) + 65'(b));
	endfunction

	function automatic logic signed [31:0] ssub(input logic signed [31:0] a,
		input logic signed [31:0] b);
		return sat32(65'(a) - 65'(b));
	endfunction

	function automatic logic signed [31:0] sneg(input logic signed [31:0] a);
		return sat32(-65'(a));
	endfunction

	function automatic vec_t vadd(input vec_t a, input vec_t b);
		vec_t r;
		r.x = sadd(a.x, b.x);
		r.y = sadd(a.y, b.y);
		return r;
	endfunction

	function automatic vec_t vsub(input vec_t a, input vec_t b);
		vec_t r;
		r.x = ssub(a.x, b.x);
		r.y = ssub(a.y, b.y);
		return r;
	endfunction

	function automatic vec_t vneg(input vec_t a);
		vec_t r;
		r.x = sneg(a.x);
		r.y = sneg(a.y);
		return r;
	endfunction

	function automatic vec_t vperp(input vec_t a);
		vec_t r;
		r.x = sneg(a.y);
		r.y = a.x;
		return r;
	endfunction

endpackage

// ===== hw/rtl/gjk_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// GJK request queue
// Accepts requests, tags test requests, and holds up to two requests for the engine.
// ----------------------------------------------------------------------------
module gjk_cmd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [2:0]         operation,
	input  logic               polygon,
	input  logic signed [31:0] value_x,
	input  logic signed [31:0] value_y,
	output logic               busy,
	input  logic               pop,
	output logic               head_valid,
	output gjk_pkg::item_t     head
);

	gjk_pkg::item_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           push;
	gjk_pkg::item_t incoming;

	always_comb begin
		incoming.op      = gjk_pkg::op_t'(operation);
		incoming.polygon = polygon;
		incoming.v.x     = value_x;
		incoming.v.y     = value_y;
		incoming.is_test = (gjk_pkg::op_t'(operation) == gjk_pkg::OP_TEST);
	end

	assign busy       = (count_q == 2'd2);
	assign push       = start && !busy;
	assign head_valid = (count_q != 2'd0);
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= incoming;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop && head_valid) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop && head_valid);
		end
	end

endmodule

// ===== hw/rtl/gjk_engine.sv =====
// ----------------------------------------------------------------------------
// GJK engine
// Executes loading requests and runs the GJK sequence on one shared multiplier.
// ----------------------------------------------------------------------------
module gjk_engine #(
	parameter int MAX_VERTICES  = 64,
	parameter int FRACTION_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  gjk_pkg::cfg_t    cfg,
	input  logic             head_valid,
	input  gjk_pkg::item_t   head,
	output logic             pop,
	output gjk_pkg::result_t res
);

	localparam int IW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam logic signed [31:0] ONE_Q = 32'sh1 <<< FRACTION_BITS;

	typedef enum logic [5:0] {
		ST_IDLE, ST_TSTART,
		ST_CG0, ST_CG1, ST_CG2,
		ST_V0, ST_V1, ST_V2, ST_V3, ST_V4, ST_V5,
		ST_V6, ST_V7, ST_V8, ST_V9, ST_V10, ST_V11,
		ST_D0, ST_D1, ST_D2,
		ST_CHK1, ST_LOOP, ST_CHKL, ST_RENTRY,
		ST_R2A, ST_R2B, ST_R2C, ST_R2D, ST_R2E, ST_R2F,
		ST_R3A, ST_R3B, ST_R3C, ST_R3D, ST_R3E
	} state_t;

	// Vertex memory, one half per polygon.
	gjk_pkg::vec_t mem [2 ** (IW + 1)];
	logic [IW:0]   rd_addr_q;
	gjk_pkg::vec_t rd_q;
	logic          we;
	logic [IW:0]   wa;

	state_t state_q, ret_q;
	logic [CW-1:0] cnt_q [2];
	gjk_pkg::vec_t pose_pos_q [2];
	gjk_pkg::vec_t pose_org_q [2];
	gjk_pkg::vec_t pose_scl_q [2];
	gjk_pkg::vec_t pose_cog_q [2];
	gjk_pkg::vec_t pose_cs_q  [2];

	gjk_pkg::vec_t cg_q, vp_q, rel_q, rt_q, fin_q, bestpt_q, s0_q, pt_q;
	gjk_pkg::vec_t dir_q, sd_q, va_q, vb_q, vc_q, vd_q, du_q, dv_q;
	gjk_pkg::vec_t sp_q [3];
	logic signed [31:0] t_q;
	logic signed [63:0] acc_q, best_q, dres_q, r1_q, r2_q, r3_q;
	logic signed [63:0] prod_q;
	logic          dsub_q;
	logic [1:0]    ssize_q;
	logic [6:0]    iter_q;
	logic [IW-1:0] vidx_q;
	logic          pp_q;
	logic          first_q;
	gjk_pkg::result_t res_q;

	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] fl, dp, eps64, neps64;
	logic signed [31:0] mq;
	logic signed [32:0] eps33;
	gjk_pkg::vec_t d0, winner, pdiff, psel;
	logic take;

	assign fl     = prod_q >>> FRACTION_BITS;
	assign mq     = gjk_pkg::sat32(65'(fl));
	assign dp     = acc_q + fl;
	assign eps64  = {48'd0, cfg.eps};
	assign neps64 = -eps64;
	assign eps33  = {17'd0, cfg.eps};
	assign pop    = (state_q == ST_IDLE) && head_valid;
	assign res    = res_q;
	assign take   = (vidx_q == '0) || (dp > best_q);
	assign winner = take ? fin_q : bestpt_q;
	assign pdiff  = gjk_pkg::vsub(s0_q, winner);
	assign psel   = (dres_q > eps64) ? gjk_pkg::vneg(vd_q) : vd_q;

	always_comb begin
		d0 = gjk_pkg::vsub(pose_pos_q[1], pose_pos_q[0]);
		if (33'(d0.x) < eps33 && 33'(d0.x) > -eps33 &&
			33'(d0.y) < eps33 && 33'(d0.y) > -eps33) begin
			d0.x = ONE_Q;
			d0.y = '0;
		end
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_CG0: begin
				mul_a = gjk_pkg::ssub(pose_cog_q[pp_q].x, pose_org_q[pp_q].x);
				mul_b = pose_scl_q[pp_q].x;
			end
			ST_CG1: begin
				mul_a = gjk_pkg::ssub(pose_cog_q[pp_q].y, pose_org_q[pp_q].y);
				mul_b = pose_scl_q[pp_q].y;
			end
			ST_V0: begin
				mul_a = gjk_pkg::ssub(rd_q.x, pose_org_q[pp_q].x);
				mul_b = pose_scl_q[pp_q].x;
			end
			ST_V1: begin
				mul_a = gjk_pkg::ssub(rd_q.y, pose_org_q[pp_q].y);
				mul_b = pose_scl_q[pp_q].y;
			end
			ST_V3: begin
				mul_a = rel_q.x;
				mul_b = pose_cs_q[pp_q].x;
			end
			ST_V4: begin
				mul_a = rel_q.y;
				mul_b = pose_cs_q[pp_q].y;
			end
			ST_V5: begin
				mul_a = rel_q.y;
				mul_b = pose_cs_q[pp_q].x;
			end
			ST_V6: begin
				mul_a = rel_q.x;
				mul_b = pose_cs_q[pp_q].y;
			end
			ST_V9: begin
				mul_a = fin_q.x;
				mul_b = sd_q.x;
			end
			ST_V10: begin
				mul_a = fin_q.y;
				mul_b = sd_q.y;
			end
			ST_D0: begin
				mul_a = du_q.x;
				mul_b = dv_q.x;
			end
			ST_D1: begin
				mul_a = du_q.y;
				mul_b = dv_q.y;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign we = pop && !head.is_test && (head.op == gjk_pkg::OP_VERTEX) &&
		(cnt_q[head.polygon] < CW'(MAX_VERTICES));
	assign wa = {head.polygon, cnt_q[head.polygon][IW-1:0]};

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= head.v;
		end
		rd_q   <= mem[rd_addr_q];
		prod_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ret_q     <= ST_IDLE;
			res_q     <= '0;
			cnt_q     <= '{default: '0};
			pose_pos_q <= '{default: '0};
			pose_org_q <= '{default: '0};
			pose_scl_q <= '{default: '0};
			pose_cog_q <= '{default: '0};
			pose_cs_q  <= '{default: '0};
			cg_q <= '0; vp_q <= '0; rel_q <= '0; rt_q <= '0; fin_q <= '0;
			bestpt_q <= '0; s0_q <= '0; pt_q <= '0; dir_q <= '0; sd_q <= '0;
			va_q <= '0; vb_q <= '0; vc_q <= '0; vd_q <= '0; du_q <= '0; dv_q <= '0;
			sp_q <= '{default: '0};
			t_q <= '0; acc_q <= '0; best_q <= '0; dres_q <= '0;
			r1_q <= '0; r2_q <= '0; r3_q <= '0;
			dsub_q <= 1'b0; ssize_q <= '0; iter_q <= '0; vidx_q <= '0;
			pp_q <= 1'b0; first_q <= 1'b0; rd_addr_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					// Every result is issued on the way back to idle, so the
					// strobe drops here, in the cycle after it rose.
					res_q.valid <= 1'b0;
					if (head_valid) begin
						if (head.is_test) begin
							state_q <= ST_TSTART;
						end else begin
							unique case (head.op)
								gjk_pkg::OP_CLEAR: cnt_q[head.polygon] <= '0;
								gjk_pkg::OP_VERTEX: begin
									if (we) begin
										cnt_q[head.polygon] <= cnt_q[head.polygon] + CW'(1);
									end
								end
								gjk_pkg::OP_POSITION: pose_pos_q[head.polygon] <= head.v;
								gjk_pkg::OP_ORIGIN:   pose_org_q[head.polygon] <= head.v;
								gjk_pkg::OP_SCALE:    pose_scl_q[head.polygon] <= head.v;
								gjk_pkg::OP_COG:      pose_cog_q[head.polygon] <= head.v;
								gjk_pkg::OP_ROTATION: pose_cs_q[head.polygon]  <= head.v;
								default: ;
							endcase
						end
					end
				end
				ST_TSTART: begin
					if (cnt_q[0] == '0 || cnt_q[1] == '0) begin
						res_q <= '{1'b1, 1'b0, gjk_pkg::OUT_EMPTY, 7'd0};
						state_q <= ST_IDLE;
					end else begin
						dir_q   <= d0;
						sd_q    <= d0;
						pp_q    <= 1'b0;
						first_q <= 1'b1;
						state_q <= ST_CG0;
					end
				end
				// Support search over one polygon.
				ST_CG0: begin
					rd_addr_q <= {pp_q, {IW{1'b0}}};
					vidx_q    <= '0;
					state_q   <= ST_CG1;
				end
				ST_CG1: begin
					cg_q.x  <= mq;
					state_q <= ST_CG2;
				end
				ST_CG2: begin
					cg_q.y  <= mq;
					state_q <= ST_V0;
				end
				ST_V0: state_q <= ST_V1;
				ST_V1: begin
					vp_q.x  <= mq;
					state_q <= ST_V2;
				end
				ST_V2: begin
					vp_q.y  <= mq;
					rel_q.x <= gjk_pkg::ssub(vp_q.x, cg_q.x);
					state_q <= ST_V3;
				end
				ST_V3: begin
					rel_q.y <= gjk_pkg::ssub(vp_q.y, cg_q.y);
					state_q <= ST_V4;
				end
				ST_V4: begin
					t_q     <= mq;
					state_q <= ST_V5;
				end
				ST_V5: begin
					rt_q.x  <= gjk_pkg::sadd(t_q, mq);
					state_q <= ST_V6;
				end
				ST_V6: begin
					t_q     <= mq;
					state_q <= ST_V7;
				end
				ST_V7: begin
					rt_q.y  <= gjk_pkg::ssub(t_q, mq);
					state_q <= ST_V8;
				end
				ST_V8: begin
					fin_q   <= gjk_pkg::vadd(gjk_pkg::vadd(rt_q, cg_q), pose_pos_q[pp_q]);
					state_q <= ST_V9;
				end
				ST_V9: state_q <= ST_V10;
				ST_V10: begin
					acc_q     <= fl;
					rd_addr_q <= {pp_q, vidx_q + IW'(1)};
					state_q   <= ST_V11;
				end
				ST_V11: begin
					if (take) begin
						best_q   <= dp;
						bestpt_q <= fin_q;
					end
					if (CW'(vidx_q) + CW'(1) < cnt_q[pp_q]) begin
						vidx_q  <= vidx_q + IW'(1);
						state_q <= ST_V0;
					end else if (!pp_q) begin
						s0_q    <= winner;
						pp_q    <= 1'b1;
						sd_q    <= gjk_pkg::vneg(dir_q);
						state_q <= ST_CG0;
					end else begin
						pt_q    <= pdiff;
						du_q    <= pdiff;
						dv_q    <= dir_q;
						dsub_q  <= 1'b0;
						ret_q   <= first_q ? ST_CHK1 : ST_CHKL;
						state_q <= ST_D0;
					end
				end
				// Dot or cross product of du and dv.
				ST_D0: state_q <= ST_D1;
				ST_D1: begin
					acc_q   <= fl;
					state_q <= ST_D2;
				end
				ST_D2: begin
					dres_q  <= dsub_q ? (acc_q - fl) : (acc_q + fl);
					state_q <= ret_q;
				end
				ST_CHK1: begin
					if (dres_q < neps64) begin
						res_q <= '{1'b1, 1'b0, gjk_pkg::OUT_FIRST_SHORT, 7'd0};
						state_q <= ST_IDLE;
					end else begin
						sp_q[0] <= pt_q;
						ssize_q <= 2'd1;
						dir_q   <= gjk_pkg::vneg(pt_q);
						iter_q  <= '0;
						state_q <= ST_LOOP;
					end
				end
				ST_LOOP: begin
					if (iter_q >= cfg.max_iter) begin
						res_q <= '{1'b1, 1'b0, gjk_pkg::OUT_LIMIT, cfg.max_iter};
						state_q <= ST_IDLE;
					end else begin
						iter_q  <= iter_q + 7'd1;
						sd_q    <= dir_q;
						pp_q    <= 1'b0;
						first_q <= 1'b0;
						state_q <= ST_CG0;
					end
				end
				ST_CHKL: begin
					if (dres_q < neps64) begin
						res_q <= '{1'b1, 1'b0, gjk_pkg::OUT_LATER_SHORT, iter_q};
						state_q <= ST_IDLE;
					end else begin
						if (ssize_q < 2'd3) begin
							sp_q[ssize_q] <= pt_q;
							ssize_q <= ssize_q + 2'd1;
						end
						state_q <= ST_RENTRY;
					end
				end
				ST_RENTRY: begin
					if (ssize_q == 2'd2) begin
						va_q    <= gjk_pkg::vneg(sp_q[1]);
						vb_q    <= gjk_pkg::vsub(sp_q[0], sp_q[1]);
						state_q <= ST_R2A;
					end else if (ssize_q == 2'd3) begin
						va_q    <= gjk_pkg::vneg(sp_q[2]);
						vb_q    <= gjk_pkg::vsub(sp_q[1], sp_q[2]);
						vc_q    <= gjk_pkg::vsub(sp_q[0], sp_q[2]);
						state_q <= ST_R3A;
					end else begin
						state_q <= ST_LOOP;
					end
				end
				// Segment case: a is the newest point, ab toward the older one.
				ST_R2A: begin
					du_q    <= vb_q;
					dv_q    <= '{va_q.y, va_q.x};
					dsub_q  <= 1'b1;
					ret_q   <= ST_R2B;
					state_q <= ST_D0;
				end
				ST_R2B: begin
					r1_q    <= dres_q;
					du_q    <= va_q;
					dv_q    <= vb_q;
					dsub_q  <= 1'b0;
					ret_q   <= ST_R2C;
					state_q <= ST_D0;
				end
				ST_R2C: begin
					r2_q    <= dres_q;
					du_q    <= va_q;
					dv_q    <= va_q;
					ret_q   <= ST_R2D;
					state_q <= ST_D0;
				end
				ST_R2D: begin
					r3_q    <= dres_q;
					du_q    <= vb_q;
					dv_q    <= vb_q;
					ret_q   <= ST_R2E;
					state_q <= ST_D0;
				end
				ST_R2E: begin
					if (r1_q < eps64 && r1_q > neps64 && r2_q >= neps64 &&
						r3_q <= dres_q) begin
						dir_q   <= gjk_pkg::vperp(vb_q);
						state_q <= ST_LOOP;
					end else if (r2_q > eps64) begin
						vd_q    <= gjk_pkg::vperp(vb_q);
						du_q    <= gjk_pkg::vperp(vb_q);
						dv_q    <= va_q;
						ret_q   <= ST_R2F;
						state_q <= ST_D0;
					end else begin
						sp_q[0] <= sp_q[1];
						ssize_q <= 2'd1;
						dir_q   <= va_q;
						state_q <= ST_LOOP;
					end
				end
				ST_R2F: begin
					dir_q   <= (dres_q < neps64) ? gjk_pkg::vneg(vd_q) : vd_q;
					state_q <= ST_LOOP;
				end
				// Triangle case: test the edge normals of ab and then ac.
				ST_R3A: begin
					vd_q    <= gjk_pkg::vperp(vb_q);
					du_q    <= gjk_pkg::vperp(vb_q);
					dv_q    <= vc_q;
					dsub_q  <= 1'b0;
					ret_q   <= ST_R3B;
					state_q <= ST_D0;
				end
				ST_R3B: begin
					vd_q    <= psel;
					du_q    <= psel;
					dv_q    <= va_q;
					ret_q   <= ST_R3C;
					state_q <= ST_D0;
				end
				ST_R3C: begin
					if (dres_q > eps64) begin
						sp_q[0] <= sp_q[1];
						sp_q[1] <= sp_q[2];
						ssize_q <= 2'd2;
						dir_q   <= vd_q;
						state_q <= ST_LOOP;
					end else begin
						vd_q    <= gjk_pkg::vperp(vc_q);
						du_q    <= gjk_pkg::vperp(vc_q);
						dv_q    <= vb_q;
						ret_q   <= ST_R3D;
						state_q <= ST_D0;
					end
				end
				ST_R3D: begin
					vd_q    <= psel;
					du_q    <= psel;
					dv_q    <= va_q;
					ret_q   <= ST_R3E;
					state_q <= ST_D0;
				end
				ST_R3E: begin
					if (dres_q > eps64) begin
						sp_q[1] <= sp_q[2];
						ssize_q <= 2'd2;
						dir_q   <= vd_q;
						state_q <= ST_LOOP;
					end else begin
						res_q <= '{1'b1, 1'b1, gjk_pkg::OUT_ENCLOSED, iter_q};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== hw/rtl/gjk_polygon_overlap_test_core.sv =====
// ----------------------------------------------------------------------------
// GJK polygon overlap test core
// Loads two posed convex polygons and runs a fixed-point 2D GJK overlap test.
// ----------------------------------------------------------------------------
//
// Channel   | Signals                                       | Transfer
// ----------+-----------------------------------------------+---------------------------
// request   | start, operation, polygon, value_x, value_y   | start high while busy low
// result    | done, collides, outcome, iterations_used      | done high for one cycle
// config    | cfg_valid, cfg_index, cfg_data, cfg_ready     | cfg_valid and cfg_ready high
//
// A request enters a two-entry queue and is executed by the engine in the cycle
// in which it is at the head while the engine is idle, so back-to-back loading
// requests are absorbed at one per cycle while no test runs. A test request is
// paced by the single shared 32x32 multiplier, through which each support pass
// runs every vertex of a polygon and each dot product both of its terms.
// While a test runs, the queue fills and busy rises after two more requests.
// Reset clears the queue, the vertex counts, the pose and the registers to
// their defaults; results cannot be stalled, done is a single-cycle strobe.
// ----------------------------------------------------------------------------
module gjk_polygon_overlap_test_core #(
	parameter int MAX_VERTICES  = 64,
	parameter int FRACTION_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// Request channel.
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         operation,
	input  logic               polygon,
	input  logic signed [31:0] value_x,
	input  logic signed [31:0] value_y,
	// Result channel.
	output logic               done,
	output logic               collides,
	output logic [2:0]         outcome,
	output logic [6:0]         iterations_used,
	// Configuration channel.
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [0:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	gjk_pkg::cfg_t    cfg_q;
	gjk_pkg::item_t   head;
	gjk_pkg::result_t res;
	logic             head_valid;
	logic             pop;

	// Always ready; the user must write only while the core is idle (unenforced).
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_iter <= 7'd16;
			cfg_q.eps      <= 16'd66;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				gjk_pkg::CFG_MAX_ITER: cfg_q.max_iter <= cfg_data[6:0];
				gjk_pkg::CFG_EPSILON:  cfg_q.eps      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front end: accepts and classifies requests into the queue.
	gjk_cmd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.operation  (operation),
		.polygon    (polygon),
		.value_x    (value_x),
		.value_y    (value_y),
		.busy       (busy),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// Back end: executes loads and runs the GJK sequence.
	gjk_engine #(
		.MAX_VERTICES  (MAX_VERTICES),
		.FRACTION_BITS (FRACTION_BITS)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.res        (res)
	);

	assign done            = res.valid;
	assign collides        = res.collides;
	assign outcome         = res.outcome;
	assign iterations_used = res.used;

endmodule

// ===== hw/rtl/gjk_checker.sv =====
// ----------------------------------------------------------------------------
// GJK core port checker
// Watches the result ports of the core for consistent outcomes.
// ----------------------------------------------------------------------------
module gjk_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       done,
	input logic       collides,
	input logic [2:0] outcome,
	input logic [6:0] iterations_used
);

	// Each result passes through idle, where the strobe is cleared, so results never come back to back.
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("two results in consecutive cycles");

	assert property (@(posedge clk) disable iff (!arst_n)
		(done && collides) |-> (outcome == gjk_pkg::OUT_ENCLOSED))
		else $error("collision reported without enclosed outcome");

	assert property (@(posedge clk) disable iff (!arst_n)
		(done && outcome == gjk_pkg::OUT_ENCLOSED) |-> collides)
		else $error("enclosed outcome without collision flag");

	assert property (@(posedge clk) disable iff (!arst_n)
		(done && (outcome == gjk_pkg::OUT_EMPTY || outcome == gjk_pkg::OUT_FIRST_SHORT))
		|-> (iterations_used == 7'd0))
		else $error("early exit with nonzero step count");

endmodule

bind gjk_polygon_overlap_test_core gjk_checker u_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.done            (done),
	.collides        (collides),
	.outcome         (outcome),
	.iterations_used (iterations_used)
);
